>>> hw/rtl/pcf_pkg.sv
// Shared types, constants and helper functions of the pitch complementary filter.
package pcf_pkg;

  localparam int RawW    = 16;  // raw sensor sample
  localparam int OffW    = 15;  // accelerometer offset register
  localparam int WgtW    = 17;  // blend weight register
  localparam int GainW   = 20;  // bias gain register
  localparam int CfgW    = 20;  // configuration data, widest register
  localparam int CfgIdxW = 4;   // configuration register index
  localparam int VecW    = 21;  // offset-corrected accelerometer value, tenths of LSB
  localparam int CordW   = 24;  // CORDIC vector components
  localparam int AngW    = 28;  // angles, Q.24 radians
  localparam int MulAW   = 35;  // signed operand of the shared multiplier
  localparam int MulBW   = 24;  // unsigned operand of the shared multiplier
  localparam int MulPW   = 60;  // full product
  localparam int MulLoW  = 17;  // low slice of the signed operand
  localparam int MulPartW = MulAW - MulLoW + MulBW + 1;  // one partial product
  localparam int EstW    = 32;  // pitch and bias estimates
  localparam int OutW    = 16;  // output pitch, Q3.13
  localparam int AtanLen = 24;

  localparam logic signed [AngW-1:0] AngPi = 28'sd52707179;
  localparam logic [MulBW-1:0] GyroStepK = 24'd6108398;
  localparam logic [WgtW-1:0] WeightOne = 17'd65536;

  localparam logic signed [AngW-1:0] AtanQ24 [AtanLen] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACC_Y_OFF = 4'd0,
    CFG_ACC_Z_OFF = 4'd1,
    CFG_BLEND_WGT = 4'd2,
    CFG_BIAS_GAIN = 4'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_ERR,
    S_BIAS,
    S_BLEND,
    S_DONE
  } seq_state_e;

  typedef enum logic {
    CORD_IDLE,
    CORD_RUN
  } cord_state_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI,
    MUL_ACC
  } mul_phase_e;

  typedef struct packed {
    logic                    start;
    logic signed [MulAW-1:0] a;
    logic [MulBW-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [MulPW-1:0] prod;
  } mul_rsp_t;

  // Clamp to the 32 bit signed range.
  function automatic logic signed [EstW-1:0] sat32(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd2147483647;
    lo = -48'sd2147483648;
    if (v > hi) begin
      return hi[EstW-1:0];
    end else if (v < lo) begin
      return lo[EstW-1:0];
    end
    return v[EstW-1:0];
  endfunction

  // Clamp to the 16 bit signed output range.
  function automatic logic signed [OutW-1:0] sat16(input logic signed [21:0] v);
    logic signed [21:0] hi;
    logic signed [21:0] lo;
    hi = 22'sd32767;
    lo = -22'sd32768;
    if (v > hi) begin
      return hi[OutW-1:0];
    end else if (v < lo) begin
      return lo[OutW-1:0];
    end
    return v[OutW-1:0];
  endfunction

endpackage

>>> hw/rtl/pcf_if.sv
// Handshake channels for IMU sample words and pitch result words.
interface pcf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [pcf_pkg::RawW-1:0]   acc_y_raw;
  logic signed [pcf_pkg::RawW-1:0]   acc_z_raw;
  logic signed [pcf_pkg::RawW-1:0]   gyro_x_raw;

  modport source (output valid, acc_y_raw, acc_z_raw, gyro_x_raw, input ready);
  modport sink (input valid, acc_y_raw, acc_z_raw, gyro_x_raw, output ready);
endinterface

interface pcf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pcf_pkg::OutW-1:0]   pitch_angle;

  modport source (output valid, pitch_angle, input ready);
  modport sink (input valid, pitch_angle, output ready);
endinterface

>>> hw/rtl/pcf_cordic.sv
// Iterative vectoring CORDIC that returns atan2(y, x) in Q.24 radians.
module pcf_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pcf_pkg::VecW-1:0]     y_i,
  input  logic signed [pcf_pkg::VecW-1:0]     x_i,
  output logic                                done_o,
  output logic signed [pcf_pkg::AngW-1:0]     angle_o
);

  localparam int IterW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int TabW  = $clog2(pcf_pkg::AtanLen);
  localparam logic [IterW-1:0] LastIter = IterW'(STEPS - 1);

  pcf_pkg::cord_state_e state_q, state_d;
  logic [IterW-1:0] iter_q;
  logic signed [pcf_pkg::CordW-1:0] x_q, y_q, x_ext, y_ext, dx, dy;
  logic signed [pcf_pkg::AngW-1:0]  ang_q, atan_val;
  logic done_q;
  logic zero_vec;

  assign x_ext    = pcf_pkg::CordW'(x_i);
  assign y_ext    = pcf_pkg::CordW'(y_i);
  assign zero_vec = (x_i == '0) && (y_i == '0);
  assign dx       = y_q >>> iter_q;
  assign dy       = x_q >>> iter_q;
  assign atan_val = pcf_pkg::AtanQ24[TabW'(iter_q)];

  always_comb begin
    state_d = state_q;
    case (state_q)
      pcf_pkg::CORD_IDLE: begin
        if (start_i && !zero_vec) begin
          state_d = pcf_pkg::CORD_RUN;
        end
      end
      pcf_pkg::CORD_RUN: begin
        if (iter_q == LastIter) begin
          state_d = pcf_pkg::CORD_IDLE;
        end
      end
      default: state_d = pcf_pkg::CORD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcf_pkg::CORD_IDLE;
      iter_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (state_q == pcf_pkg::CORD_IDLE) begin
        iter_q <= '0;
        if (start_i && zero_vec) begin
          done_q <= 1'b1;
        end
      end else begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == LastIter) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pcf_pkg::CORD_IDLE) begin
      if (start_i) begin
        if (zero_vec) begin
          x_q   <= '0;
          y_q   <= '0;
          ang_q <= '0;
        end else if (x_i < 0) begin
          // Turn the vector by pi so that it lies in the right half plane.
          x_q   <= -x_ext;
          y_q   <= -y_ext;
          ang_q <= (y_i >= 0) ? pcf_pkg::AngPi : -pcf_pkg::AngPi;
        end else begin
          x_q   <= x_ext;
          y_q   <= y_ext;
          ang_q <= '0;
        end
      end
    end else if (y_q > 0) begin
      x_q   <= x_q + dx;
      y_q   <= y_q - dy;
      ang_q <= ang_q + atan_val;
    end else begin
      x_q   <= x_q - dx;
      y_q   <= y_q + dy;
      ang_q <= ang_q - atan_val;
    end
  end

  assign done_o  = done_q;
  assign angle_o = ang_q;

endmodule

>>> hw/rtl/pcf_mul.sv
// Shared multiplier: signed 35 bit times unsigned 24 bit in two partial products.
module pcf_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcf_pkg::mul_req_t req_i,
  output pcf_pkg::mul_rsp_t rsp_o
);

  pcf_pkg::mul_phase_e phase_q, phase_d;
  logic signed [pcf_pkg::MulAW-1:0]    a_q;
  logic [pcf_pkg::MulBW-1:0]           b_q;
  logic signed [pcf_pkg::MulPartW-1:0] part_q, part_d;
  logic signed [pcf_pkg::MulPW-1:0]    acc_q;
  logic signed [pcf_pkg::MulBW:0]      b_s;
  logic signed [pcf_pkg::MulLoW:0]     a_lo;
  logic signed [pcf_pkg::MulAW-pcf_pkg::MulLoW-1:0] a_hi;
  logic done_q;

  assign b_s  = $signed({1'b0, b_q});
  assign a_lo = $signed({1'b0, a_q[pcf_pkg::MulLoW-1:0]});
  assign a_hi = a_q[pcf_pkg::MulAW-1:pcf_pkg::MulLoW];

  always_comb begin
    phase_d = phase_q;
    part_d  = part_q;
    case (phase_q)
      pcf_pkg::MUL_IDLE: begin
        if (req_i.start) begin
          phase_d = pcf_pkg::MUL_LO;
        end
      end
      pcf_pkg::MUL_LO: begin
        part_d  = pcf_pkg::MulPartW'(a_lo * b_s);
        phase_d = pcf_pkg::MUL_HI;
      end
      pcf_pkg::MUL_HI: begin
        part_d  = pcf_pkg::MulPartW'(a_hi * b_s);
        phase_d = pcf_pkg::MUL_ACC;
      end
      pcf_pkg::MUL_ACC: phase_d = pcf_pkg::MUL_IDLE;
      default: phase_d = pcf_pkg::MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pcf_pkg::MUL_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == pcf_pkg::MUL_ACC);
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    if (phase_q == pcf_pkg::MUL_IDLE && req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end
    if (phase_q == pcf_pkg::MUL_HI) begin
      acc_q <= pcf_pkg::MulPW'(part_q);
    end else if (phase_q == pcf_pkg::MUL_ACC) begin
      acc_q <= acc_q + (pcf_pkg::MulPW'(part_q) <<< pcf_pkg::MulLoW);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

>>> hw/rtl/pitch_complementary_filter.sv
// Pitch complementary filter: latency from an accepted sample word to a valid
// pitch word is set by the iterative CORDIC, overlapped by the first of three
// passes through the shared multiplier, and the two passes after it. Words are
// taken one at a time. A zero accelerometer vector skips the CORDIC iterations.
// Reset clears the pitch and gyro bias estimates to zero and loads the default
// offsets, blend weight and bias gain.
module pitch_complementary_filter #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pcf_pkg::CfgW-1:0]      cfg_data_i,
  pcf_in_if.sink                        in_i,
  pcf_out_if.source                     out_o
);

  // Configuration registers.
  logic signed [pcf_pkg::OffW-1:0] acc_y_off_q, acc_z_off_q;
  logic [pcf_pkg::WgtW-1:0]        blend_wgt_q;
  logic [pcf_pkg::GainW-1:0]       bias_gain_q;

  // Filter state.
  logic signed [pcf_pkg::EstW-1:0] pitch_q, bias_q;

  // Sequencer and working registers.
  pcf_pkg::seq_state_e state_q, state_d;
  logic cord_ok_q, rate_ok_q;
  logic signed [pcf_pkg::EstW-1:0] pred_q, bias_new_q, pitch_new_q;
  logic signed [pcf_pkg::EstW:0]   err_q;
  logic out_valid_q;
  logic signed [pcf_pkg::OutW-1:0] out_pitch_q;

  logic accept;
  logic commit;
  logic cord_done;
  logic signed [pcf_pkg::AngW-1:0] cord_ang;
  pcf_pkg::mul_req_t mul_req;
  pcf_pkg::mul_rsp_t mul_rsp;

  // Offset-corrected accelerometer values in tenths of LSB: 10 * raw - offset.
  logic signed [pcf_pkg::VecW-1:0] acc_y_ext, acc_z_ext, vec_y, vec_z;
  assign acc_y_ext = pcf_pkg::VecW'(in_i.acc_y_raw);
  assign acc_z_ext = pcf_pkg::VecW'(in_i.acc_z_raw);
  assign vec_y = (acc_y_ext <<< 3) + (acc_y_ext <<< 1) - pcf_pkg::VecW'(acc_y_off_q);
  assign vec_z = (acc_z_ext <<< 3) + (acc_z_ext <<< 1) - pcf_pkg::VecW'(acc_z_off_q);

  // Gyro rate less bias, Q16.16 gyro LSB.
  logic signed [pcf_pkg::MulAW-1:0] rate;
  assign rate = pcf_pkg::MulAW'($signed({in_i.gyro_x_raw, 16'h0000}))
              - pcf_pkg::MulAW'(bias_q);

  // Rounded scaling of the multiplier product (add half, then floor).
  logic signed [pcf_pkg::MulPW-1:0] prod_r32, prod_r24, prod_r16;
  assign prod_r32 = mul_rsp.prod + (pcf_pkg::MulPW'(1) <<< 31);
  assign prod_r24 = mul_rsp.prod + (pcf_pkg::MulPW'(1) <<< 23);
  assign prod_r16 = mul_rsp.prod + (pcf_pkg::MulPW'(1) <<< 15);

  logic signed [27:0] gyro_inc;
  logic signed [35:0] bias_step;
  logic signed [43:0] blend_step;
  assign gyro_inc   = prod_r32[59:32];
  assign bias_step  = prod_r24[59:24];
  assign blend_step = prod_r16[59:16];

  logic signed [47:0] pred_sum, bias_sum, pitch_sum;
  assign pred_sum  = 48'(pitch_q) + 48'(gyro_inc);
  assign bias_sum  = 48'(bias_q) - 48'(bias_step);
  assign pitch_sum = 48'(pred_q) + 48'(blend_step);

  // Error between the observed (minus the CORDIC angle) and predicted pitch.
  logic signed [pcf_pkg::EstW:0] err;
  assign err = -(pcf_pkg::EstW+1)'(cord_ang) - (pcf_pkg::EstW+1)'(pred_q);

  // The blend weight is capped at one.
  logic [pcf_pkg::WgtW-1:0] blend_cap;
  assign blend_cap = (blend_wgt_q > pcf_pkg::WeightOne) ? pcf_pkg::WeightOne : blend_wgt_q;

  // Output rounding to Q3.13.
  logic signed [21:0] out_round;
  assign out_round = 22'((33'(pitch_new_q) + 33'sd1024) >>> 11);

  assign accept = in_i.valid && in_i.ready;

  // Sequencer: the CORDIC and the rate product run side by side; the bias and
  // blend products follow one after the other on the shared multiplier.
  always_comb begin
    state_d       = state_q;
    in_i.ready    = 1'b0;
    commit        = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = rate;
    mul_req.b     = pcf_pkg::GyroStepK;
    case (state_q)
      pcf_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          mul_req.start = 1'b1;
          state_d       = pcf_pkg::S_WAIT;
        end
      end
      pcf_pkg::S_WAIT: begin
        if ((cord_ok_q || cord_done) && rate_ok_q) begin
          state_d = pcf_pkg::S_ERR;
        end
      end
      pcf_pkg::S_ERR: begin
        mul_req.start = 1'b1;
        mul_req.a     = pcf_pkg::MulAW'(err);
        mul_req.b     = pcf_pkg::MulBW'(bias_gain_q);
        state_d       = pcf_pkg::S_BIAS;
      end
      pcf_pkg::S_BIAS: begin
        mul_req.a = pcf_pkg::MulAW'(err_q);
        mul_req.b = pcf_pkg::MulBW'(blend_cap);
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          state_d       = pcf_pkg::S_BLEND;
        end
      end
      pcf_pkg::S_BLEND: begin
        if (mul_rsp.done) begin
          state_d = pcf_pkg::S_DONE;
        end
      end
      pcf_pkg::S_DONE: begin
        // Wait until the output register is free, then update the state.
        if (!out_valid_q || out_o.ready) begin
          commit  = 1'b1;
          state_d = pcf_pkg::S_IDLE;
        end
      end
      default: state_d = pcf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcf_pkg::S_IDLE;
      cord_ok_q   <= 1'b0;
      rate_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pitch_q     <= '0;
      bias_q      <= '0;
      acc_y_off_q <= 15'sd378;
      acc_z_off_q <= -15'sd572;
      blend_wgt_q <= 17'd3277;
      bias_gain_q <= 20'd11796;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cord_ok_q <= 1'b0;
        rate_ok_q <= 1'b0;
      end else if (state_q == pcf_pkg::S_WAIT) begin
        if (cord_done) begin
          cord_ok_q <= 1'b1;
        end
        if (mul_rsp.done) begin
          rate_ok_q <= 1'b1;
        end
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        pitch_q     <= pitch_new_q;
        bias_q      <= bias_new_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pcf_pkg::CFG_ACC_Y_OFF: acc_y_off_q <= cfg_data_i[pcf_pkg::OffW-1:0];
          pcf_pkg::CFG_ACC_Z_OFF: acc_z_off_q <= cfg_data_i[pcf_pkg::OffW-1:0];
          pcf_pkg::CFG_BLEND_WGT: blend_wgt_q <= cfg_data_i[pcf_pkg::WgtW-1:0];
          pcf_pkg::CFG_BIAS_GAIN: bias_gain_q <= cfg_data_i[pcf_pkg::GainW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers; no reset needed.
  always_ff @(posedge clk_i) begin
    if (state_q == pcf_pkg::S_WAIT && state_d == pcf_pkg::S_ERR) begin
      pred_q <= pcf_pkg::sat32(pred_sum);
    end
    if (state_q == pcf_pkg::S_ERR) begin
      err_q <= err;
    end
    if (state_q == pcf_pkg::S_BIAS && mul_rsp.done) begin
      bias_new_q <= pcf_pkg::sat32(bias_sum);
    end
    if (state_q == pcf_pkg::S_BLEND && mul_rsp.done) begin
      pitch_new_q <= pcf_pkg::sat32(pitch_sum);
    end
    if (commit) begin
      out_pitch_q <= pcf_pkg::sat16(out_round);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pitch_angle = out_pitch_q;

  pcf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .y_i     (vec_y),
    .x_i     (vec_z),
    .done_o  (cord_done),
    .angle_o (cord_ang)
  );

  pcf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // The CORDIC finishes only while the sequencer waits for it.
  a_cord_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> state_q == pcf_pkg::S_WAIT)
    else $error("CORDIC result outside of the wait state");

  // Multiplier results arrive only in states that consume them.
  a_mul_done_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == pcf_pkg::S_WAIT || state_q == pcf_pkg::S_BIAS ||
                      state_q == pcf_pkg::S_BLEND))
    else $error("multiplier result dropped");

  // A commit in the final state of an item presents a result word, with the sequencer back in idle.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && state_q == pcf_pkg::S_IDLE)
    else $error("result word not presented after commit");

  // Both the angle and the rate product are in when the error is formed.
  a_operands_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pcf_pkg::S_ERR |-> cord_ok_q && rate_ok_q)
    else $error("error formed before its operands");

endmodule

>>> bench/testbench.sv
// Self-checking bench for the pitch complementary filter: random IMU words, bit-exact predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 11;
  localparam int CordicSteps  = 16;
  // The tail and settle waits cover the latency of one sample word.
  localparam int TailCycles   = 2 * (CordicSteps + 11);
  localparam int SettleCycles = 4;
  // Longest quiet stretch of a correct run is the longest sender gap, the block's
  // own processing and the longest receiver stall; this is many times that.
  localparam int StallLimit   = 2000;
  localparam int MaxReports   = 200;

  // Index that decodes to no register; a write to it must change nothing.
  localparam logic [pcf_pkg::CfgIdxW-1:0] CfgIdxSpare = 4'd15;

  // Fixed-point constants of the filter, Q.24 radians unless noted.
  localparam longint AnglePiQ24 = 64'sd52707179;
  localparam longint GyroStepK  = 64'sd6108398;   // round(2^40 / 180000)
  localparam longint EstLo      = -64'sd2147483648;
  localparam longint EstHi      = 64'sd2147483647;
  localparam longint OutLo      = -64'sd32768;
  localparam longint OutHi      = 64'sd32767;
  localparam longint UnityQ16   = 64'sd65536;

  localparam longint ArctanQ24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  // How the random sample words move: a level sensor with modest rotation,
  // or a hard spin one way or the other that winds up the estimates.
  typedef enum logic [1:0] {
    MOTION_LEVEL,
    MOTION_SPIN_DOWN,
    MOTION_SPIN_UP
  } motion_e;

  // Receiver behavior, picked anew at random when its run ends.
  typedef enum logic [1:0] {
    TAKE_ALL,
    TAKE_COIN,
    TAKE_COMB,
    TAKE_TRICKLE
  } take_e;

  // One pending sample word. The drain flag holds it back until every
  // expected pitch word has come out.
  typedef struct packed {
    logic                            drain;
    logic signed [pcf_pkg::RawW-1:0] acc_y;
    logic signed [pcf_pkg::RawW-1:0] acc_z;
    logic signed [pcf_pkg::RawW-1:0] gyro_x;
  } imu_word_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [pcf_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [pcf_pkg::CfgW-1:0]    cfg_data_i;

  pcf_in_if  in_if ();
  pcf_out_if out_if ();

  pitch_complementary_filter #(
    .CORDIC_STEPS(CordicSteps)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Mirror of the configuration registers, reset values included.
  logic signed [pcf_pkg::OffW-1:0] y_offset     = 15'sd378;
  logic signed [pcf_pkg::OffW-1:0] z_offset     = -15'sd572;
  logic [pcf_pkg::WgtW-1:0]        blend_weight = 17'd3277;
  logic [pcf_pkg::GainW-1:0]       bias_gain    = 20'd11796;

  // Mirror of the filter state: pitch in Q8.24 radians, bias in Q16.16 gyro LSB.
  longint pitch_q24 = 0;
  longint bias_q16  = 0;

  imu_word_t                         sample_q [$];
  logic signed [pcf_pkg::OutW-1:0]   expected_pitch_q [$];
  int unsigned                       error_count = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Scaling shift that rounds half up: add half, then floor.
  function automatic longint shr_round(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Vectoring CORDIC angle of (x, y). A vector in the left half plane is
  // turned by pi first, with the start angle taking the sign of y.
  function automatic longint vector_angle(input longint y, input longint x);
    longint ang;
    longint dx;
    longint dy;
    int     i;
    ang = 0;
    if (x == 0 && y == 0) begin
      return 0;
    end
    if (x < 0) begin
      ang = (y >= 0) ? AnglePiQ24 : -AnglePiQ24;
      x = -x;
      y = -y;
    end
    for (i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        ang += ArctanQ24[i];
      end else begin
        x -= dx;
        y += dy;
        ang -= ArctanQ24[i];
      end
    end
    return ang;
  endfunction

  // Runs one sample through the filter mirror and returns the pitch word.
  function automatic logic signed [pcf_pkg::OutW-1:0] advance_filter(
    input logic signed [pcf_pkg::RawW-1:0] acc_y,
    input logic signed [pcf_pkg::RawW-1:0] acc_z,
    input logic signed [pcf_pkg::RawW-1:0] gyro_x
  );
    longint y;
    longint z;
    longint observed;
    longint rate;
    longint predicted;
    longint err;
    longint weight;
    longint gain;
    y = longint'(acc_y) * 10 - longint'(y_offset);
    z = longint'(acc_z) * 10 - longint'(z_offset);
    observed = -vector_angle(y, z);
    rate = longint'(gyro_x) * 65536 - bias_q16;
    predicted = clamp(pitch_q24 + shr_round(rate * GyroStepK, 32), EstLo, EstHi);
    err = observed - predicted;
    // A weight above one acts as exactly one.
    weight = (blend_weight > pcf_pkg::WgtW'(UnityQ16)) ? UnityQ16 : longint'(blend_weight);
    gain = longint'(bias_gain);
    bias_q16 = clamp(bias_q16 - shr_round(gain * err, 24), EstLo, EstHi);
    pitch_q24 = clamp(predicted + shr_round(weight * err, 16), EstLo, EstHi);
    return pcf_pkg::OutW'(clamp(shr_round(pitch_q24, 11), OutLo, OutHi));
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MaxReports) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic push_word(input int acc_y, input int acc_z, input int gyro_x);
    imu_word_t w;
    w.drain  = 1'b0;
    w.acc_y  = pcf_pkg::RawW'(acc_y);
    w.acc_z  = pcf_pkg::RawW'(acc_z);
    w.gyro_x = pcf_pkg::RawW'(gyro_x);
    sample_q.push_back(w);
  endtask

  // Queues a run of random sample words. About one in four is pure noise
  // across the full field range; the rest follow the requested motion.
  task automatic queue_motion(input int count, input motion_e motion, input int drain_at);
    imu_word_t w;
    int        mag;
    int        n;
    for (n = 0; n < count; n++) begin
      mag = span(500, 20000);
      if ($urandom_range(0, 3) == 0) begin
        w.acc_y = pcf_pkg::RawW'($urandom);
        w.acc_z = pcf_pkg::RawW'($urandom);
      end else begin
        w.acc_y = pcf_pkg::RawW'(span(-mag, mag));
        w.acc_z = pcf_pkg::RawW'(span(-mag, mag));
      end
      case (motion)
        MOTION_SPIN_DOWN: w.gyro_x = pcf_pkg::RawW'(span(-32768, -32700));
        MOTION_SPIN_UP:   w.gyro_x = pcf_pkg::RawW'(span(32700, 32767));
        default: begin
          w.gyro_x = ($urandom_range(0, 3) == 0) ? pcf_pkg::RawW'($urandom)
                                                  : pcf_pkg::RawW'(span(-4000, 4000));
        end
      endcase
      w.drain = (n == drain_at);
      sample_q.push_back(w);
    end
  endtask

  // Blocks until every queued word has been taken and every expected pitch
  // word has arrived, then waits for the block to settle.
  task automatic wait_for_drain();
    while (sample_q.size() != 0 || in_if.valid || expected_pitch_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register write; the mirror follows the same decode, so a write to
  // an unused index leaves it untouched.
  task automatic write_reg(input logic [pcf_pkg::CfgIdxW-1:0] idx,
                           input logic [pcf_pkg::CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      pcf_pkg::CFG_ACC_Y_OFF: y_offset     = data[pcf_pkg::OffW-1:0];
      pcf_pkg::CFG_ACC_Z_OFF: z_offset     = data[pcf_pkg::OffW-1:0];
      pcf_pkg::CFG_BLEND_WGT: blend_weight = data[pcf_pkg::WgtW-1:0];
      pcf_pkg::CFG_BIAS_GAIN: bias_gain    = data[pcf_pkg::GainW-1:0];
      default: ;
    endcase
  endtask

  // Writes all four registers. Bits above a register's width carry junk,
  // which the block must drop.
  task automatic set_filter(input int y_off, input int z_off,
                            input int unsigned weight, input int unsigned gain);
    write_reg(pcf_pkg::CFG_ACC_Y_OFF, {5'($urandom), 15'(y_off)});
    write_reg(pcf_pkg::CFG_ACC_Z_OFF, {5'($urandom), 15'(z_off)});
    write_reg(pcf_pkg::CFG_BLEND_WGT, {3'($urandom), 17'(weight)});
    write_reg(pcf_pkg::CFG_BIAS_GAIN, 20'(gain));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    int y_off;
    int z_off;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SettleCycles) @(posedge clk_i);

    // Reset configuration: field extremes, and a vector in the left half
    // plane with y on either side of zero.
    push_word(32767, 32767, 32767);
    push_word(-32768, -32768, -32768);
    push_word(0, 0, 0);
    push_word(1000, -1000, 0);
    push_word(-1000, -1000, -1);
    push_word(-32768, 32767, 32767);
    wait_for_drain();

    // Offsets of zero make the zero vector and the axes reachable; the
    // weight sits above one, so the pitch snaps to the observed angle.
    write_reg(CfgIdxSpare, pcf_pkg::CfgW'($urandom));
    set_filter(0, 0, 131071, 0);
    push_word(0, 0, 5);
    push_word(0, -7, 0);
    push_word(-1, -7, 0);
    push_word(3, 0, 0);
    push_word(-3, 0, 0);
    push_word(32767, 0, -32768);
    wait_for_drain();

    // Back to the reset settings with ordinary motion, including a pause
    // until the pipeline has fully emptied.
    set_filter(378, -572, 3277, 11796);
    queue_motion(150, MOTION_LEVEL, 75);
    wait_for_drain();

    // Gyro-only blend with the largest bias gain while spinning down: the
    // bias chases the rate and runs into its lower limit, and the pitch
    // swings far enough to saturate the output word.
    y_off = span(-10000, 10000);
    z_off = span(-10000, 10000);
    write_reg(CfgIdxSpare, pcf_pkg::CfgW'($urandom));
    set_filter(y_off, z_off, 0, 1048575);
    queue_motion(250, MOTION_SPIN_DOWN, -1);
    wait_for_drain();

    // Bias frozen and the gyro pinned near its top: the pitch integrates up
    // to the limit of its 32 bit estimate and stays there.
    set_filter(y_off, z_off, 0, 0);
    queue_motion(500, MOTION_SPIN_UP, -1);
    wait_for_drain();

    // Weight of exactly one with the offsets at their extremes.
    set_filter(-16384, 16383, 65536, 0);
    queue_motion(80, MOTION_LEVEL, -1);
    wait_for_drain();

    // Fully random settings.
    set_filter(span(-10000, 10000), span(-10000, 10000),
               $urandom_range(0, 131071), $urandom_range(0, 1048575));
    queue_motion(100, MOTION_LEVEL, 50);
    wait_for_drain();

    set_filter(16383, -16384, 3277, 11796);
    queue_motion(45, MOTION_LEVEL, -1);
    wait_for_drain();

    // Anything that shows up now was never asked for.
    repeat (TailCycles) @(posedge clk_i);
    if (expected_pitch_q.size() != 0) begin
      report_mismatch($sformatf("%0d pitch words never arrived", expected_pitch_q.size()));
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sample driver: bursts of words with random gaps between them. A word
  // is predicted at the edge that accepts it, so the mirror always sees
  // the words in the block's own order.
  // ---------------------------------------------------------------------------

  imu_word_t next_word;
  int        burst_left;
  int        gap_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.acc_y_raw  <= '0;
      in_if.acc_z_raw  <= '0;
      in_if.gyro_x_raw <= '0;
      burst_left  = 1;
      gap_left    = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_pitch_q.push_back(
          advance_filter(in_if.acc_y_raw, in_if.acc_z_raw, in_if.gyro_x_raw));
      end
      // A word on offer stays until it is taken.
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (sample_q.size() != 0 &&
                     !(sample_q[0].drain && expected_pitch_q.size() != 0)) begin
          next_word        = sample_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.acc_y_raw  <= next_word.acc_y;
          in_if.acc_z_raw  <= next_word.acc_z;
          in_if.gyro_x_raw <= next_word.gyro_x;
          burst_left--;
          if (burst_left <= 0) begin
            // Now and then a long back-to-back stretch, otherwise short
            // bursts with gaps that land on every cycle of the block's work.
            if ($urandom_range(0, 5) == 0) begin
              burst_left = $urandom_range(20, 60);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 8);
              gap_left   = $urandom_range(0, 45);
            end
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pitch monitor: checks each accepted word against the oldest prediction,
  // and drives ready from a pattern that is picked anew when its run ends.
  // ---------------------------------------------------------------------------

  take_e                           take_mode;
  int                              take_left;
  int unsigned                     take_phase;
  logic signed [pcf_pkg::OutW-1:0] expected_pitch;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      take_mode    = TAKE_ALL;
      take_left    = 0;
      take_phase   = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_pitch_q.size() == 0) begin
          report_mismatch($sformatf("pitch word %0d with nothing expected",
                                    out_if.pitch_angle));
        end else begin
          expected_pitch = expected_pitch_q.pop_front();
          if (out_if.pitch_angle !== expected_pitch) begin
            report_mismatch($sformatf("pitch_angle %0d, expected %0d",
                                      out_if.pitch_angle, expected_pitch));
          end
        end
      end
      if (take_left <= 0) begin
        take_mode = take_e'($urandom_range(0, 3));
        take_left = $urandom_range(50, 400);
      end
      take_left--;
      take_phase++;
      case (take_mode)
        TAKE_COIN:    out_if.ready <= 1'($urandom_range(0, 1));
        TAKE_COMB:    out_if.ready <= (take_phase % 7) < 3;
        TAKE_TRICKLE: out_if.ready <= (take_phase % 41) == 0;
        default:      out_if.ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any word moving in either direction means the
  // block has hung.
  // ---------------------------------------------------------------------------

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_if.valid && in_if.ready) ||
        (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TIMEOUT @%0t: no word accepted for %0d cycles", $time, StallLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> pitch_complementary_filter.f
hw/rtl/pcf_pkg.sv
hw/rtl/pcf_if.sv
hw/rtl/pcf_cordic.sv
hw/rtl/pcf_mul.sv
hw/rtl/pitch_complementary_filter.sv
bench/testbench.sv
